// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BDG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define BDG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bdg_pkg.sv =====
// Shared types and constants of the button debounce and gesture detector.
package bdg_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounce    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDoubleClick = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInitLevel   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0] DebounceRst    = TimeW'(20);
  localparam logic [TimeW-1:0] LongPressRst   = TimeW'(1000);
  localparam logic [TimeW-1:0] DoubleClickRst = TimeW'(300);
  localparam logic             InitLevelRst   = 1'b0;

  typedef enum logic [2:0] {
    GestNone   = 3'd0,
    GestPress  = 3'd1,
    GestRelease = 3'd2,
    GestClick  = 3'd3,
    GestDouble = 3'd4,
    GestLong   = 3'd5
  } gesture_e;

  // One accepted sample as seen by the gesture state machine.
  typedef struct packed {
    logic             take;   // a sample is accepted this cycle
    logic             fire;   // debounced level changes with this sample
    logic             level;  // new debounced level when fire is set
    logic [TimeW-1:0] now;
  } bdg_step_t;

endpackage

// ===== src/bdg_fsm.sv =====
// Gesture state machine: turns debounced level changes into gesture events.
module bdg_fsm import bdg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  bdg_step_t        step_i,
  input  logic [TimeW-1:0] long_press_time_i,
  input  logic [TimeW-1:0] double_click_window_i,
  output gesture_e         gesture_o
);

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StPressed = 3'd1,
    StLong    = 3'd2,
    StWait    = 3'd3,
    StSecond  = 3'd4
  } state_e;

  state_e           state_q, state_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] release_time_q, release_time_d;
  logic [TimeW-1:0] since_press, since_release;
  gesture_e         gest;

  assign since_press   = step_i.now - press_time_q;
  assign since_release = step_i.now - release_time_q;

  always_comb begin
    state_d        = state_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    gest           = GestNone;
    if (step_i.fire && step_i.level) begin
      unique case (state_q)
        StIdle: begin
          state_d      = StPressed;
          press_time_d = step_i.now;
          gest         = GestPress;
        end
        StWait: begin
          press_time_d = step_i.now;
          if (since_release <= double_click_window_i) begin
            state_d = StSecond;
            gest    = GestPress;
          end else begin
            state_d = StPressed;
            gest    = GestClick;
          end
        end
        default: ;
      endcase
    end else if (step_i.fire) begin
      unique case (state_q)
        StPressed: begin
          state_d        = StWait;
          release_time_d = step_i.now;
          gest           = GestRelease;
        end
        StSecond: begin
          state_d = StIdle;
          gest    = GestDouble;
        end
        StLong: begin
          state_d = StIdle;
          gest    = GestRelease;
        end
        default: ;
      endcase
    end
    // Timeouts only when no edge event came out of this sample.
    if (gest == GestNone) begin
      unique case (state_q)
        StPressed, StSecond: begin
          if (since_press >= long_press_time_i) begin
            state_d = StLong;
            gest    = GestLong;
          end
        end
        StWait: begin
          if (since_release >= double_click_window_i) begin
            state_d = StIdle;
            gest    = GestClick;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else if (restart_i) begin
      state_q        <= StIdle;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else if (step_i.take) begin
      state_q        <= state_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
    end
  end

  assign gesture_o = gest;

endmodule

// ===== src/button_debounce_gesture_detector.sv =====
// Top level of the button debounce and gesture detector.
// Each input transaction carries one raw button sample (level_i, 1 = pressed)
// and a wrapping millisecond timestamp; each one yields exactly one output
// transaction with a gesture code (none, press, release, click, double click,
// long press). A raw level change restarts the debounce timer; once the raw
// level has differed from the accepted level for debounce_time ms it is taken
// as the new level and fed to the gesture state machine. Long-press and
// double-click timeouts are checked only when no edge event fired for that
// sample. All time differences wrap modulo 2^32. The block takes one sample
// per clock: the whole update (three wrapping subtracts with compares and
// the state machine) is combinational into the output register, so a new
// transaction is accepted every cycle unless the output register is full and
// stalled; each result is shown from the cycle after its sample is taken.
// Configuration writes are taken at once, with no wait; any write reloads the
// initial level and sends the state machine back to idle with cleared time
// stamps. Write the configuration only while no transaction is in flight.
module button_debounce_gesture_detector import bdg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               level_i,
  input  logic [TimeW-1:0]   timestamp_i,
  // gesture channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         gesture_o
);

  // Configuration registers.
  logic [TimeW-1:0] debounce_q, long_press_q, double_click_q;
  logic             init_level_q;

  // Debounce state.
  logic             raw_q, stable_q;
  logic [TimeW-1:0] edge_time_q;

  // Output register.
  logic             out_valid_q;
  gesture_e         gesture_q;

  logic             take;
  logic             raw_change;
  logic [TimeW-1:0] since_edge;
  logic             init_level_d;
  bdg_step_t        step;
  gesture_e         gesture_d;

  // Take a sample whenever the output register is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // A raw change restarts the timer, so the elapsed time is zero then.
  assign raw_change = level_i != raw_q;
  assign since_edge = raw_change ? '0 : (timestamp_i - edge_time_q);

  assign step.take  = take;
  assign step.fire  = (level_i != stable_q) && (since_edge >= debounce_q);
  assign step.level = level_i;
  assign step.now   = timestamp_i;

  // Level that a config write restarts from (new value if this write sets it).
  assign init_level_d = (cfg_idx_i == CfgInitLevel) ? cfg_wdata_i[0] : init_level_q;

  bdg_fsm u_fsm (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .restart_i             (cfg_we_i),
    .step_i                (step),
    .long_press_time_i     (long_press_q),
    .double_click_window_i (double_click_q),
    .gesture_o             (gesture_d)
  );

  // Configuration registers: store the written value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DebounceRst;
      long_press_q   <= LongPressRst;
      double_click_q <= DoubleClickRst;
      init_level_q   <= InitLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:    debounce_q     <= cfg_wdata_i[TimeW-1:0];
        CfgLongPress:   long_press_q   <= cfg_wdata_i[TimeW-1:0];
        CfgDoubleClick: double_click_q <= cfg_wdata_i[TimeW-1:0];
        CfgInitLevel:   init_level_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Debounce: track the raw level and time of its last change.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= InitLevelRst;
      stable_q    <= InitLevelRst;
      edge_time_q <= '0;
    end else if (cfg_we_i) begin
      raw_q       <= init_level_d;
      stable_q    <= init_level_d;
      edge_time_q <= '0;
    end else if (take) begin
      if (raw_change) begin
        raw_q       <= level_i;
        edge_time_q <= timestamp_i;
      end
      if (step.fire) begin
        stable_q <= level_i;
      end
    end
  end

  // Output register: load on take, drop when the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

endmodule

// ===== src/bdg_checker.sv =====
// Port-level checker for the gesture detector, bound to the top level.
`include "assert_macros.svh"

module bdg_checker import bdg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         gesture_o
);

  // Every accepted transaction shows up on the output next cycle.
  `BDG_ASSERT_NEXT(a_in_to_out, in_valid_i && in_ready_o, out_valid_o)

  // A full, stalled output register blocks the input side.
  `BDG_ASSERT(a_stall_blocks_in, (out_valid_o && !out_ready_i) |-> !in_ready_o)

  // A stalled result holds its code.
  `BDG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(gesture_o))

  // Only defined gesture codes leave the block.
  `BDG_ASSERT(a_code_range, out_valid_o |-> (gesture_o <= 3'(GestLong)))

  // With the output side empty, the block is always ready.
  `BDG_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)

endmodule

bind button_debounce_gesture_detector bdg_checker u_bdg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .gesture_o   (gesture_o)
);
